>>> design/polar_rect_vector_alu_assert.svh
// assertion macros for the polar_rect_vector_alu block
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef POLAR_RECT_VECTOR_ALU_ASSERT_SVH
`define POLAR_RECT_VECTOR_ALU_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("polar_rect_vector_alu: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("polar_rect_vector_alu: next-cycle check failed");

`endif

>>> design/pra_pkg.sv
// shared types, constants and functions of the polar_rect_vector_alu block
// no dependencies
`default_nettype none

package pra_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int FRACTION_BITS     = 16;

    localparam int XY_W     = 32;
    localparam int SUM_W    = XY_W + 1;
    localparam int ANGLE_W  = 34;
    localparam int COORD_W  = 34;
    localparam int COORD_FB = 30;
    localparam int PROD_W   = XY_W + COORD_W;

    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   =
        (CORDIC_ITERATIONS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;

    typedef logic [2:0] t_op;

    localparam t_op OP_RECT  = 3'd0;
    localparam t_op OP_POLAR = 3'd1;
    localparam t_op OP_ADD   = 3'd2;
    localparam t_op OP_SUB   = 3'd3;
    localparam t_op OP_NEG   = 3'd4;
    localparam t_op OP_SCALE = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ANGLE_W-1:0] z;
        logic                      flip;
    } t_rot;

    typedef struct packed {
        logic                   polar;
        logic signed [XY_W-1:0] mag;
        logic signed [XY_W-1:0] rx;
        logic signed [XY_W-1:0] ry;
        logic                   bad;
        logic                   sat;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0] value;
        logic                   hit;
    } t_clamp;

    // angles in Q6.28
    localparam logic signed [ANGLE_W-1:0] Q28_PI      = ANGLE_W'(843314857);
    localparam logic signed [ANGLE_W-1:0] Q28_TWO_PI  = ANGLE_W'(1686629713);
    localparam logic signed [ANGLE_W-1:0] Q28_HALF_PI = ANGLE_W'(421657428);

    localparam logic signed [ANGLE_W-1:0] ATAN_SMALL [10] = '{
        ANGLE_W'(210828714), ANGLE_W'(124459457), ANGLE_W'(65760959),
        ANGLE_W'(33381290),  ANGLE_W'(16755422),  ANGLE_W'(8385879),
        ANGLE_W'(4193963),   ANGLE_W'(2097109),   ANGLE_W'(1048571),
        ANGLE_W'(524287)
    };

    // inverse cordic gain in Q4.30 for 8..15 steps, then the limit
    localparam logic signed [COORD_W-1:0] GAIN_TABLE [9] = '{
        COORD_W'(652039507), COORD_W'(652034532), COORD_W'(652033289),
        COORD_W'(652032978), COORD_W'(652032900), COORD_W'(652032881),
        COORD_W'(652032876), COORD_W'(652032875), COORD_W'(652032874)
    };

    localparam int GAIN_IDX = (CORDIC_ITERATIONS < 8) ? 0 :
                              ((CORDIC_ITERATIONS > 16) ? 8 : CORDIC_ITERATIONS - 8);
    localparam logic signed [COORD_W-1:0] GAIN_Q30 = GAIN_TABLE[GAIN_IDX];

    function automatic logic signed [ANGLE_W-1:0] angle_step(input int i);
        logic signed [ANGLE_W-1:0] unit;
        unit = ANGLE_W'(1);
        if (i < 10) begin
            return ATAN_SMALL[i[3:0]];
        end else if (i <= 28) begin
            return unit <<< (28 - i);
        end
        return '0;
    endfunction

    function automatic t_clamp sat32(input logic signed [PROD_W-1:0] v);
        t_clamp c;
        c.hit = !((&v[PROD_W-1:XY_W-1]) || !(|v[PROD_W-1:XY_W-1]));
        if (c.hit) begin
            c.value = v[PROD_W-1] ? {1'b1, {(XY_W-1){1'b0}}} : {1'b0, {(XY_W-1){1'b1}}};
        end else begin
            c.value = v[XY_W-1:0];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/pra_front.sv
// front stages: operation decode, vector arithmetic, scale product, angle reduction
// depends on pra_pkg
`default_nettype none

module pra_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pra_pkg::t_op                  i_operation,
    input  logic signed [pra_pkg::XY_W-1:0] i_first_x,
    input  logic signed [pra_pkg::XY_W-1:0] i_first_y,
    input  logic signed [pra_pkg::XY_W-1:0] i_second_x,
    input  logic signed [pra_pkg::XY_W-1:0] i_second_y,
    input  logic signed [pra_pkg::XY_W-1:0] i_factor,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pra_pkg::t_rot                 o_rot,
    output pra_pkg::t_side                o_side
);
    import pra_pkg::*;

    localparam logic signed [PROD_W-1:0] SCALE_RND = PROD_W'(1) << (FRACTION_BITS - 1);

    function automatic logic signed [ANGLE_W-1:0] wrap_angle(
        input logic signed [ANGLE_W-1:0] z
    );
        if (z > Q28_PI) begin
            return z - Q28_TWO_PI;
        end else if (z < -Q28_PI) begin
            return z + Q28_TWO_PI;
        end
        return z;
    endfunction

    function automatic t_rot fold_angle(input logic signed [ANGLE_W-1:0] z);
        t_rot r;
        r.x    = GAIN_Q30;
        r.y    = '0;
        r.z    = z;
        r.flip = 1'b0;
        if (z > Q28_HALF_PI) begin
            r.z    = z - Q28_PI;
            r.flip = 1'b1;
        end else if (z < -Q28_HALF_PI) begin
            r.z    = z + Q28_PI;
            r.flip = 1'b1;
        end
        return r;
    endfunction

    logic w_en1, w_en2, w_en3;

    // stage 1
    logic                      r1_valid;
    t_op                       r1_op;
    logic signed [XY_W-1:0]    r1_mag;
    logic signed [ANGLE_W-1:0] r1_z;
    logic signed [SUM_W-1:0]   r1_lx, r1_ly;
    logic                      r1_bad;
    logic signed [2*XY_W-1:0]  r1_px, r1_py;

    logic signed [ANGLE_W-1:0] n1_z;
    logic signed [SUM_W-1:0]   n1_lx, n1_ly;
    logic                      n1_bad;
    logic signed [2*XY_W-1:0]  n1_px, n1_py;

    // stage 2
    logic                      r2_valid;
    logic signed [ANGLE_W-1:0] r2_z;
    t_side                     r2_side;

    logic signed [ANGLE_W-1:0] n2_z;
    t_side                     n2_side;
    logic signed [PROD_W-1:0]  w2_scx, w2_scy;
    t_clamp                    w2_cx, w2_cy;

    // stage 3
    logic                      r3_valid;
    t_rot                      r3_rot;
    t_side                     r3_side;

    assign w_en3   = !r3_valid || i_ready;
    assign w_en2   = !r2_valid || w_en3;
    assign w_en1   = !r1_valid || w_en2;
    assign o_ready = w_en1;

    assign n1_z  = wrap_angle(ANGLE_W'(i_first_y));
    assign n1_px = (2*XY_W)'(i_first_x) * (2*XY_W)'(i_factor);
    assign n1_py = (2*XY_W)'(i_first_y) * (2*XY_W)'(i_factor);

    always_comb begin
        n1_lx  = '0;
        n1_ly  = '0;
        n1_bad = 1'b0;
        unique case (i_operation)
            OP_RECT: begin
                n1_lx = SUM_W'(i_first_x);
                n1_ly = SUM_W'(i_first_y);
            end
            OP_POLAR, OP_SCALE: begin
                n1_lx = '0;
                n1_ly = '0;
            end
            OP_ADD: begin
                n1_lx = SUM_W'(i_first_x) + SUM_W'(i_second_x);
                n1_ly = SUM_W'(i_first_y) + SUM_W'(i_second_y);
            end
            OP_SUB: begin
                n1_lx = SUM_W'(i_first_x) - SUM_W'(i_second_x);
                n1_ly = SUM_W'(i_first_y) - SUM_W'(i_second_y);
            end
            OP_NEG: begin
                n1_lx = -SUM_W'(i_first_x);
                n1_ly = -SUM_W'(i_first_y);
            end
            default: begin
                n1_bad = 1'b1;
            end
        endcase
    end

    // scale rounds to nearest, then both paths saturate
    assign w2_scx = (PROD_W'(r1_px) + SCALE_RND) >>> FRACTION_BITS;
    assign w2_scy = (PROD_W'(r1_py) + SCALE_RND) >>> FRACTION_BITS;

    always_comb begin
        if (r1_op == OP_SCALE) begin
            w2_cx = sat32(w2_scx);
            w2_cy = sat32(w2_scy);
        end else begin
            w2_cx = sat32(PROD_W'(r1_lx));
            w2_cy = sat32(PROD_W'(r1_ly));
        end
        n2_side.polar = (r1_op == OP_POLAR);
        n2_side.mag   = r1_mag;
        n2_side.rx    = w2_cx.value;
        n2_side.ry    = w2_cy.value;
        n2_side.bad   = r1_bad;
        n2_side.sat   = w2_cx.hit || w2_cy.hit;
    end

    assign n2_z = wrap_angle(r1_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_en1) r1_valid <= i_valid;
            if (w_en2) r2_valid <= r1_valid;
            if (w_en3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_op  <= i_operation;
            r1_mag <= i_first_x;
            r1_z   <= n1_z;
            r1_lx  <= n1_lx;
            r1_ly  <= n1_ly;
            r1_bad <= n1_bad;
            r1_px  <= n1_px;
            r1_py  <= n1_py;
        end
        if (w_en2) begin
            r2_z    <= n2_z;
            r2_side <= n2_side;
        end
        if (w_en3) begin
            r3_rot  <= fold_angle(r2_z);
            r3_side <= r2_side;
        end
    end

    assign o_valid = r3_valid;
    assign o_rot   = r3_rot;
    assign o_side  = r3_side;

endmodule

`default_nettype wire

>>> design/pra_cordic.sv
// rotation-mode cordic pipeline, a fixed number of iterations per register stage
// depends on pra_pkg
`default_nettype none

module pra_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pra_pkg::t_rot   i_rot,
    input  pra_pkg::t_side  i_side,
    output logic            o_valid,
    input  logic            i_ready,
    output pra_pkg::t_rot   o_rot,
    output pra_pkg::t_side  o_side
);
    import pra_pkg::*;

    function automatic t_rot cordic_step(input t_rot r, input int i);
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ANGLE_W-1:0] z;
        t_rot                      q;
        x = r.x;
        y = r.y;
        z = r.z;
        q = r;
        if (i < CORDIC_ITERATIONS) begin
            if (!z[ANGLE_W-1]) begin
                q.x = x - (y >>> i);
                q.y = y + (x >>> i);
                q.z = z - angle_step(i);
            end else begin
                q.x = x + (y >>> i);
                q.y = y - (x >>> i);
                q.z = z + angle_step(i);
            end
        end
        return q;
    endfunction

    logic [CORDIC_STAGES-1:0] r_valid;
    t_rot                     r_rot  [CORDIC_STAGES];
    t_side                    r_side [CORDIC_STAGES];

    logic [CORDIC_STAGES-1:0] w_en;
    logic [CORDIC_STAGES-1:0] w_vchain;
    t_rot                     w_rchain [CORDIC_STAGES];
    t_side                    w_schain [CORDIC_STAGES];
    t_rot                     n_rot    [CORDIC_STAGES];

    always_comb begin
        w_vchain[0] = i_valid;
        w_rchain[0] = i_rot;
        w_schain[0] = i_side;
        for (int s = 0; s < CORDIC_STAGES - 1; s++) begin
            w_vchain[s+1] = r_valid[s];
            w_rchain[s+1] = r_rot[s];
            w_schain[s+1] = r_side[s];
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[CORDIC_STAGES-1] = !r_valid[CORDIC_STAGES-1] || i_ready;
        for (int s = CORDIC_STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_valid[s] || w_en[s+1];
        end
    end

    always_comb begin
        for (int s = 0; s < CORDIC_STAGES; s++) begin
            n_rot[s] = w_rchain[s];
            for (int k = 0; k < ITERS_PER_STAGE; k++) begin
                n_rot[s] = cordic_step(n_rot[s], s * ITERS_PER_STAGE + k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int s = 0; s < CORDIC_STAGES; s++) begin
                if (w_en[s]) r_valid[s] <= w_vchain[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < CORDIC_STAGES; s++) begin
            if (w_en[s]) begin
                r_rot[s]  <= n_rot[s];
                r_side[s] <= w_schain[s];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_valid[CORDIC_STAGES-1];
    assign o_rot   = r_rot[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];

endmodule

`default_nettype wire

>>> design/pra_back.sv
// back stages: magnitude product, rounding, saturation and the output register
// depends on pra_pkg
`default_nettype none

module pra_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  pra_pkg::t_rot                   i_rot,
    input  pra_pkg::t_side                  i_side,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [pra_pkg::XY_W-1:0] o_result_x,
    output logic signed [pra_pkg::XY_W-1:0] o_result_y,
    output logic                            o_bad_operation,
    output logic                            o_saturated
);
    import pra_pkg::*;

    localparam logic signed [PROD_W-1:0] POLAR_RND = PROD_W'(1) << (COORD_FB - 1);

    logic w_en1, w_en2;

    logic signed [XY_W-1:0]    w_mag;
    logic signed [COORD_W-1:0] w_xf, w_yf, w_x, w_y;
    logic signed [PROD_W-1:0]  n1_px, n1_py;

    logic                      r1_valid;
    logic signed [PROD_W-1:0]  r1_px, r1_py;
    t_side                     r1_side;

    logic signed [PROD_W-1:0]  w2_rx, w2_ry;
    t_clamp                    w2_cx, w2_cy;
    logic signed [XY_W-1:0]    n2_rx, n2_ry;
    logic                      n2_sat;

    logic                      r2_valid;
    logic signed [XY_W-1:0]    r2_rx, r2_ry;
    logic                      r2_bad, r2_sat;

    assign w_en2   = !r2_valid || i_ready;
    assign w_en1   = !r1_valid || w_en2;
    assign o_ready = w_en1;

    assign w_mag = i_side.mag;
    assign w_x   = i_rot.x;
    assign w_y   = i_rot.y;
    assign w_xf  = i_rot.flip ? -w_x : w_x;
    assign w_yf  = i_rot.flip ? -w_y : w_y;
    assign n1_px = PROD_W'(w_mag) * PROD_W'(w_xf);
    assign n1_py = PROD_W'(w_mag) * PROD_W'(w_yf);

    assign w2_rx = (r1_px + POLAR_RND) >>> COORD_FB;
    assign w2_ry = (r1_py + POLAR_RND) >>> COORD_FB;
    assign w2_cx = sat32(w2_rx);
    assign w2_cy = sat32(w2_ry);

    always_comb begin
        if (r1_side.polar) begin
            n2_rx  = w2_cx.value;
            n2_ry  = w2_cy.value;
            n2_sat = w2_cx.hit || w2_cy.hit;
        end else begin
            n2_rx  = r1_side.rx;
            n2_ry  = r1_side.ry;
            n2_sat = r1_side.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (w_en1) r1_valid <= i_valid;
            if (w_en2) r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_px   <= n1_px;
            r1_py   <= n1_py;
            r1_side <= i_side;
        end
        if (w_en2) begin
            r2_rx  <= n2_rx;
            r2_ry  <= n2_ry;
            r2_bad <= r1_side.bad;
            r2_sat <= n2_sat;
        end
    end

    assign o_valid         = r2_valid;
    assign o_result_x      = r2_rx;
    assign o_result_y      = r2_ry;
    assign o_bad_operation = r2_bad;
    assign o_saturated     = r2_sat;

endmodule

`default_nettype wire

>>> design/polar_rect_vector_alu.sv
// top level of the 2-D vector unit: front stages, cordic pipeline, back stages
// depends on pra_pkg, pra_front, pra_cordic, pra_back, polar_rect_vector_alu_assert.svh
//
// channel   direction  handshake           payload
// input     in         i_valid / o_ready   operation, first_x/y, second_x/y, factor
// result    out        o_valid / i_ready   result_x/y, bad_operation, saturated
//
// one transaction per cycle sustained while i_ready is high, every operation takes the same path
// the cordic pipeline runs 24 iterations, two per register stage
// synchronous active-low reset clears the stage valid bits only, no clearing pass
// a stall holds occupied stages; empty stages keep moving and close bubbles
`default_nettype none

`include "polar_rect_vector_alu_assert.svh"

module polar_rect_vector_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  pra_pkg::t_op                    i_operation,
    input  logic signed [pra_pkg::XY_W-1:0] i_first_x,
    input  logic signed [pra_pkg::XY_W-1:0] i_first_y,
    input  logic signed [pra_pkg::XY_W-1:0] i_second_x,
    input  logic signed [pra_pkg::XY_W-1:0] i_second_y,
    input  logic signed [pra_pkg::XY_W-1:0] i_factor,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [pra_pkg::XY_W-1:0] o_result_x,
    output logic signed [pra_pkg::XY_W-1:0] o_result_y,
    output logic                            o_bad_operation,
    output logic                            o_saturated
);
    import pra_pkg::*;

    logic  w_f_valid, w_f_ready;
    t_rot  w_f_rot;
    t_side w_f_side;

    logic  w_c_valid, w_c_ready;
    t_rot  w_c_rot;
    t_side w_c_side;

    logic  w_zero_out, w_on_rail;

    pra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .i_factor    (i_factor),
        .o_valid     (w_f_valid),
        .i_ready     (w_f_ready),
        .o_rot       (w_f_rot),
        .o_side      (w_f_side)
    );

    pra_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_rot   (w_f_rot),
        .i_side  (w_f_side),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_rot   (w_c_rot),
        .o_side  (w_c_side)
    );

    pra_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_c_valid),
        .o_ready         (w_c_ready),
        .i_rot           (w_c_rot),
        .i_side          (w_c_side),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_x      (o_result_x),
        .o_result_y      (o_result_y),
        .o_bad_operation (o_bad_operation),
        .o_saturated     (o_saturated)
    );

    assign w_zero_out = (o_result_x == 0) && (o_result_y == 0) && !o_saturated;
    assign w_on_rail  = (o_result_x == 32'sh7fffffff) || (o_result_x == 32'sh80000000) ||
                        (o_result_y == 32'sh7fffffff) || (o_result_y == 32'sh80000000);

    `PRA_ASSERT_IMP(a_bad_gives_zero, o_valid && o_bad_operation, w_zero_out)
    `PRA_ASSERT_IMP(a_sat_on_rail, o_valid && o_saturated, w_on_rail)
    `PRA_ASSERT_IMP(a_ready_when_drained, !o_valid, o_ready)
    `PRA_ASSERT_NXT(a_stalled_cordic_holds, w_c_valid && !w_c_ready, w_c_valid)

endmodule

`default_nettype wire
